>>> hdl/bfhp_pkg.sv
// Shared types and constants for the BNEP frame header parser.
// No dependencies; used by the front end, back end, top level and checker.
package bfhp_pkg;

    // Position and offset fields in the queue record, sized for a 16-bit packet length plus a saturation bit.
    localparam int POS_W     = 17;
    localparam int ADDR_W    = 48;
    localparam int CFG_IDX_W = 2;
    localparam int TDATA_W   = 160;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OWN_ADDR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PEER_ADDR = 2'd1;

    // BNEP packet types
    localparam logic [6:0] TYPE_GENERAL    = 7'd0;
    localparam logic [6:0] TYPE_CONTROL    = 7'd1;
    localparam logic [6:0] TYPE_COMPRESSED = 7'd2;
    localparam logic [6:0] TYPE_SRC_ONLY   = 7'd3;
    localparam logic [6:0] TYPE_DST_ONLY   = 7'd4;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_RUNT      = 3'd1,
        ST_BAD_TYPE  = 3'd2,
        ST_SHORT_HDR = 3'd3,
        ST_EXT_CUT   = 3'd4,
        ST_EXT_OVER  = 3'd5,
        ST_CONTROL   = 3'd6,
        ST_TOO_LONG  = 3'd7
    } t_status;

    // Packet summary handed from front end to back end.
    typedef struct packed {
        logic [POS_W-1:0]  len;
        logic [6:0]        ptype;
        logic              ext_pending;
        logic              ext_cut;
        logic [POS_W-1:0]  next_ext;
        logic [ADDR_W-1:0] dest;
        logic [ADDR_W-1:0] src;
        logic [15:0]       eth;
    } t_rec;

    // Fixed header length of a type; zero for unknown types.
    function automatic logic [3:0] hdr_len(input logic [6:0] t);
        logic [3:0] r;
        case (t)
            TYPE_GENERAL:    r = 4'd15;
            TYPE_CONTROL:    r = 4'd2;
            TYPE_COMPRESSED: r = 4'd3;
            TYPE_SRC_ONLY:   r = 4'd9;
            TYPE_DST_ONLY:   r = 4'd9;
            default:         r = 4'd0;
        endcase
        return r;
    endfunction

endpackage

>>> hdl/bfhp_front.sv
// Front end: takes packet bytes, captures header fields, walks extension headers.
// Depends on bfhp_pkg; pushes one t_rec per packet into the queue.
module bfhp_front #(
    parameter int LENGTH_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    input  logic             i_q_full,
    output logic             o_push,
    output bfhp_pkg::t_rec   o_rec
);
    localparam int NW = LENGTH_BITS + 1;

    logic [NW-1:0]  r_pos, n_pos;
    logic [6:0]     r_type, n_type;
    logic           r_ext_pending, n_ext_pending;
    logic           r_ext_cut, n_ext_cut;
    logic           r_ext_more, n_ext_more;
    logic [NW-1:0]  r_next, n_next;
    logic [47:0]    r_dest, n_dest;
    logic [47:0]    r_src, n_src;
    logic [15:0]    r_eth, n_eth;

    logic           accept;
    logic           pos_sat;
    logic [3:0]     hl;
    logic [3:0]     hl_new;
    logic [3:0]     p4;
    logic           in_hdr;
    logic           is_dst;
    logic           is_src;
    logic [NW:0]    ext_sum;
    logic [NW:0]    next_p1;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign pos_sat = r_pos[NW-1] || (&r_pos[NW-2:0]);
    assign hl      = bfhp_pkg::hdr_len(r_type);
    assign hl_new  = bfhp_pkg::hdr_len(i_byte[6:0]);
    assign p4      = r_pos[3:0];
    assign in_hdr  = (r_pos[NW-1:4] == '0) && (p4 < hl);
    assign ext_sum = {1'b0, r_next} + (NW+1)'(i_byte) + (NW+1)'(2);
    assign next_p1 = {1'b0, r_next} + (NW+1)'(1);

    always_comb begin
        is_dst = 1'b0;
        is_src = 1'b0;
        case (r_type)
            bfhp_pkg::TYPE_GENERAL: begin
                is_dst = (p4 <= 4'd6);
                is_src = (p4 >= 4'd7) && (p4 <= 4'd12);
            end
            bfhp_pkg::TYPE_SRC_ONLY: is_src = (p4 <= 4'd6);
            bfhp_pkg::TYPE_DST_ONLY: is_dst = (p4 <= 4'd6);
            default: ;
        endcase
    end

    always_comb begin
        n_pos         = r_pos;
        n_type        = r_type;
        n_ext_pending = r_ext_pending;
        n_ext_cut     = r_ext_cut;
        n_ext_more    = r_ext_more;
        n_next        = r_next;
        n_dest        = r_dest;
        n_src         = r_src;
        n_eth         = r_eth;
        if (accept) begin
            if (pos_sat) begin
                n_pos = {1'b1, {LENGTH_BITS{1'b0}}};
            end else begin
                n_pos = r_pos + NW'(1);
                if (r_pos == '0) begin
                    n_type        = i_byte[6:0];
                    n_ext_pending = i_byte[7] && (hl_new != 4'd0);
                    n_next        = NW'(hl_new);
                end else if (hl != 4'd0) begin
                    if (in_hdr) begin
                        if (is_dst)
                            n_dest = {r_dest[39:0], i_byte};
                        else if (is_src)
                            n_src = {r_src[39:0], i_byte};
                        else if (r_type != bfhp_pkg::TYPE_CONTROL)
                            n_eth = {r_eth[7:0], i_byte};
                    end else if (r_ext_cut && ({1'b0, r_pos} == next_p1)) begin
                        // length byte of an extension header: skip its body
                        n_next        = ext_sum[NW] ? {NW{1'b1}} : ext_sum[NW-1:0];
                        n_ext_cut     = 1'b0;
                        n_ext_pending = r_ext_more;
                    end else if (r_ext_pending && (r_pos == r_next)) begin
                        n_ext_more    = i_byte[7];
                        n_ext_cut     = 1'b1;
                        n_ext_pending = 1'b0;
                    end
                end
            end
        end
    end

    assign o_push = accept && i_last;

    always_comb begin
        o_rec             = '0;
        o_rec.len         = bfhp_pkg::POS_W'(n_pos);
        o_rec.ptype       = n_type;
        o_rec.ext_pending = n_ext_pending;
        o_rec.ext_cut     = n_ext_cut;
        o_rec.next_ext    = bfhp_pkg::POS_W'(n_next);
        o_rec.dest        = n_dest;
        o_rec.src         = n_src;
        o_rec.eth         = n_eth;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_push) begin
            r_pos         <= '0;
            r_type        <= '0;
            r_ext_pending <= 1'b0;
            r_ext_cut     <= 1'b0;
            r_ext_more    <= 1'b0;
            r_next        <= '0;
            r_dest        <= '0;
            r_src         <= '0;
            r_eth         <= '0;
        end else begin
            r_pos         <= n_pos;
            r_type        <= n_type;
            r_ext_pending <= n_ext_pending;
            r_ext_cut     <= n_ext_cut;
            r_ext_more    <= n_ext_more;
            r_next        <= n_next;
            r_dest        <= n_dest;
            r_src         <= n_src;
            r_eth         <= n_eth;
        end
    end

endmodule

>>> hdl/bfhp_fifo.sv
// Two-entry queue of packet records between front end and back end.
// Depends on nothing; width set by the instantiating module.
module bfhp_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wr_ptr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push)
                r_wr_ptr <= !r_wr_ptr;
            if (i_pop)
                r_rd_ptr <= !r_rd_ptr;
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> hdl/bfhp_back.sv
// Back end: grades a packet record, fills in missing addresses, drives the result register.
// Depends on bfhp_pkg; reads records from bfhp_fifo.
module bfhp_back #(
    parameter int LENGTH_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_q_empty,
    input  bfhp_pkg::t_rec                    i_rec,
    output logic                              o_pop,
    input  logic [bfhp_pkg::ADDR_W-1:0]       i_own_addr,
    input  logic [bfhp_pkg::ADDR_W-1:0]       i_peer_addr,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [bfhp_pkg::TDATA_W-1:0]      o_data
);
    localparam int PW = bfhp_pkg::POS_W;
    localparam logic [PW-1:0] MAX_LEN = PW'((1 << LENGTH_BITS) - 1);

    bfhp_pkg::t_status status;
    logic [3:0]        hl;
    logic [47:0]       dest;
    logic [47:0]       src;
    logic [15:0]       pstart;
    logic [15:0]       plen;
    logic [bfhp_pkg::TDATA_W-1:0] n_data;

    logic                          r_valid;
    logic [bfhp_pkg::TDATA_W-1:0]  r_data;

    assign hl    = bfhp_pkg::hdr_len(i_rec.ptype);
    assign o_pop = !i_q_empty && (!r_valid || i_ready);

    always_comb begin
        if (i_rec.len > MAX_LEN)
            status = bfhp_pkg::ST_TOO_LONG;
        else if (i_rec.len < PW'(3))
            status = bfhp_pkg::ST_RUNT;
        else if (hl == 4'd0)
            status = bfhp_pkg::ST_BAD_TYPE;
        else if (i_rec.len < PW'(hl))
            status = bfhp_pkg::ST_SHORT_HDR;
        else if (i_rec.ext_pending || i_rec.ext_cut)
            status = bfhp_pkg::ST_EXT_CUT;
        else if (i_rec.next_ext > i_rec.len)
            status = bfhp_pkg::ST_EXT_OVER;
        else if (i_rec.ptype == bfhp_pkg::TYPE_CONTROL)
            status = bfhp_pkg::ST_CONTROL;
        else
            status = bfhp_pkg::ST_OK;
    end

    always_comb begin
        dest = i_rec.dest;
        src  = i_rec.src;
        case (i_rec.ptype)
            bfhp_pkg::TYPE_COMPRESSED: begin
                dest = i_own_addr;
                src  = i_peer_addr;
            end
            bfhp_pkg::TYPE_SRC_ONLY: dest = i_own_addr;
            bfhp_pkg::TYPE_DST_ONLY: src  = i_peer_addr;
            default: ;
        endcase
        pstart = i_rec.next_ext[15:0];
        plen   = 16'(i_rec.len - i_rec.next_ext);
    end

    // Fields from the lowest bit: status, type, dest, source, ethertype, start, length.
    always_comb begin
        n_data        = '0;
        n_data[2:0]   = status;
        n_data[9:3]   = i_rec.ptype;
        if (status == bfhp_pkg::ST_OK) begin
            n_data[57:10]   = dest;
            n_data[105:58]  = src;
            n_data[121:106] = i_rec.eth;
            n_data[137:122] = pstart;
            n_data[153:138] = plen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop)
            r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> hdl/bnep_frame_header_parser.sv
// Top level of the BNEP frame header parser: configuration registers and block wiring.
// Depends on bfhp_pkg, bfhp_front, bfhp_fifo and bfhp_back.
//
// The parser takes a BNEP packet one byte per transaction on the slave stream (tlast on the
// final byte) and sustains one byte per clock: each byte costs a position compare and a
// register capture in the front end. On the final byte the front end pushes a packet record
// into a two-entry queue; the back end grades it (status, address fill from the local and
// remote address registers, payload offset and length) into an output register, which loads
// and raises the result valid on a pop while that register is empty or being read. The
// byte stream only stalls when two records wait in the queue behind a result held by a
// stalled master side. Packets longer than 2^LENGTH_BITS - 1 bytes report the too-long
// status. The user writes the address registers (index 0 local, index 1 remote) through
// the configuration channel only while no packet is in flight; the block does not check.
module bnep_frame_header_parser #(
    parameter int LENGTH_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [bfhp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bfhp_pkg::ADDR_W-1:0]        i_cfg_data,
    // byte stream in
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [7:0]                         i_s_axis_tdata,   // [7:0] data_byte
    input  logic                               i_s_axis_tlast,   // end_of_packet
    // result stream out
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // [2:0] status, [9:3] packet_type, [57:10] dest_address, [105:58] source_address,
    // [121:106] ether_type, [137:122] payload_start, [153:138] payload_length, rest zero
    output logic [bfhp_pkg::TDATA_W-1:0]       o_m_axis_tdata
);
    logic [bfhp_pkg::ADDR_W-1:0] r_own_addr;
    logic [bfhp_pkg::ADDR_W-1:0] r_peer_addr;

    bfhp_pkg::t_rec front_rec;
    bfhp_pkg::t_rec back_rec;
    logic           q_push;
    logic           q_pop;
    logic           q_full;
    logic           q_empty;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_addr  <= '0;
            r_peer_addr <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                bfhp_pkg::REG_OWN_ADDR:  r_own_addr  <= i_cfg_data;
                bfhp_pkg::REG_PEER_ADDR: r_peer_addr <= i_cfg_data;
                default: ;
            endcase
        end
    end

    bfhp_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .o_ready  (o_s_axis_tready),
        .i_byte   (i_s_axis_tdata),
        .i_last   (i_s_axis_tlast),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_rec    (front_rec)
    );

    bfhp_fifo #(
        .WIDTH ($bits(bfhp_pkg::t_rec))
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (front_rec),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (back_rec)
    );

    bfhp_back #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_rec       (back_rec),
        .o_pop       (q_pop),
        .i_own_addr  (r_own_addr),
        .i_peer_addr (r_peer_addr),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_data      (o_m_axis_tdata)
    );

endmodule

>>> hdl/bfhp_checker.sv
// Port-level checks for the BNEP frame header parser, bound to the top level.
// Depends on bfhp_pkg and bnep_frame_header_parser.
module bfhp_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_m_axis_tvalid,
    input logic                          i_m_axis_tready,
    input logic [bfhp_pkg::TDATA_W-1:0]  o_m_axis_tdata
);
    // stalled result keeps its transaction
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    // any error status zeroes everything past the type field
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tdata[2:0] != bfhp_pkg::ST_OK)
        |-> (o_m_axis_tdata[153:10] == '0))
        else $error("error result carries header fields");

    // success only for the data-carrying types
    a_ok_type: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tdata[2:0] == bfhp_pkg::ST_OK)
        |-> (o_m_axis_tdata[9:3] == bfhp_pkg::TYPE_GENERAL)
         || (o_m_axis_tdata[9:3] == bfhp_pkg::TYPE_COMPRESSED)
         || (o_m_axis_tdata[9:3] == bfhp_pkg::TYPE_SRC_ONLY)
         || (o_m_axis_tdata[9:3] == bfhp_pkg::TYPE_DST_ONLY))
        else $error("ok status on a type without a payload");

    // no result straight out of reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind bnep_frame_header_parser bfhp_checker u_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
